// ===== rtl/core/u8d_pkg.sv =====
`default_nettype none
package u8d_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned PEND_W  = 3;
    localparam int unsigned APB_W   = 32;

    localparam logic [0:0] ADDR_UNIT_CAPACITY = 1'b0;
    localparam logic [UNIT_W-1:0] UNIT_CAPACITY_RESET = 16'd64;

    localparam logic [7:0] LEAD_6 = 8'hfc;
    localparam logic [7:0] LEAD_5 = 8'hf8;
    localparam logic [7:0] LEAD_4 = 8'hf0;
    localparam logic [7:0] LEAD_3 = 8'he0;
    localparam logic [7:0] LEAD_2 = 8'hc0;

    localparam logic [7:0] MASK_CONT   = 8'h3f;
    localparam logic [7:0] MASK_LEAD_6 = 8'h01;
    localparam logic [7:0] MASK_LEAD_5 = 8'h03;
    localparam logic [7:0] MASK_LEAD_4 = 8'h07;
    localparam logic [7:0] MASK_LEAD_3 = 8'h0f;
    localparam logic [7:0] MASK_LEAD_2 = 8'h1f;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               is_end;
        logic               overflow;
        logic [COUNT_W-1:0] unit_count;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data_byte;
    } t_in_stage;

endpackage
`default_nettype wire

// ===== rtl/core/u8d_byte_if.sv =====
`default_nettype none
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/u8d_result_if.sv =====
`default_nettype none
interface u8d_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_end;
    logic        overflow;
    logic [16:0] unit_count;

    modport source (output valid, output code_unit, output is_end, output overflow,
                    output unit_count, input ready);
    modport sink (input valid, input code_unit, input is_end, input overflow,
                  input unit_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/utf8_to_ucs2_string_decoder.sv =====
`default_nettype none
// UTF-8 to 16-bit code unit decoder. Takes one byte per transaction and
// sustains one byte per clock while the result output is not stalled: each
// byte is latched in an input register, decoded there by shift and mask
// logic and, when it completes a unit or ends a string, written to the
// result register as it leaves the input register. Leads of 0xc0 and
// above open sequences of two to six bytes; the low 16 bits of the gathered
// value are emitted. A zero byte at a sequence boundary gives an end result
// with the string's unit count. Once a string would exceed unit_capacity
// (APB address 0, reset 64) an overflow end result is given and bytes are
// dropped up to the next zero. Write the capacity only while the block is idle.
module utf8_to_ucs2_string_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    u8d_byte_if.sink         i_byte,
    u8d_result_if.source     o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import u8d_pkg::*;

    logic [UNIT_W-1:0] r_capacity;
    t_in_stage         stage;
    t_result           dec_result;
    logic              dec_has;
    logic              out_free;
    logic              take;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_UNIT_CAPACITY) ? {16'h0000, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= UNIT_CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_UNIT_CAPACITY) begin
            r_capacity <= pwdata[UNIT_W-1:0];
        end
    end

    assign take = stage.valid && (!dec_has || out_free);

    u8d_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .i_data_byte (i_byte.data_byte),
        .o_ready     (i_byte.ready),
        .i_take      (take),
        .o_stage     (stage)
    );

    u8d_decode u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (take),
        .i_data_byte  (stage.data_byte),
        .i_capacity   (r_capacity),
        .o_has_result (dec_has),
        .o_result     (dec_result)
    );

    u8d_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && dec_has),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

// ===== rtl/core/u8d_in_stage.sv =====
`default_nettype none
module u8d_in_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_ready,
    input  wire logic                 i_take,
    output u8d_pkg::t_in_stage        o_stage
);
    import u8d_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_stage.valid     = r_valid;
    assign o_stage.data_byte = r_byte;
endmodule
`default_nettype wire

// ===== rtl/core/u8d_decode.sv =====
`default_nettype none
module u8d_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [15:0]       i_capacity,
    output logic                   o_has_result,
    output u8d_pkg::t_result       o_result
);
    import u8d_pkg::*;

    logic [PEND_W-1:0]  r_pending, n_pending;
    logic [UNIT_W-1:0]  r_acc, n_acc;
    logic [COUNT_W-1:0] r_units, n_units;
    logic               r_drop, n_drop;

    logic [UNIT_W-1:0]  cont_acc;
    logic [PEND_W-1:0]  cont_pending;
    logic               unit_done;
    logic [UNIT_W-1:0]  unit_val;
    logic               ovf;

    assign cont_acc     = {r_acc[UNIT_W-7:0], i_data_byte[5:0] & MASK_CONT[5:0]};
    assign cont_pending = r_pending - PEND_W'(1);
    assign ovf          = r_units >= {1'b0, i_capacity};

    always_comb begin
        n_pending    = r_pending;
        n_acc        = r_acc;
        n_units      = r_units;
        n_drop       = r_drop;
        unit_done    = 1'b0;
        unit_val     = {8'h00, i_data_byte};
        o_has_result = 1'b0;
        o_result     = '0;
        if (r_drop) begin
            if (i_data_byte == 8'h00) begin
                n_drop    = 1'b0;
                n_units   = '0;
                n_pending = '0;
                n_acc     = '0;
            end
        end else if (r_pending != '0) begin
            n_acc     = cont_acc;
            n_pending = cont_pending;
            if (cont_pending == '0) begin
                unit_done = 1'b1;
                unit_val  = cont_acc;
            end
        end else if (i_data_byte == 8'h00) begin
            o_has_result        = 1'b1;
            o_result.is_end     = 1'b1;
            o_result.unit_count = r_units;
            n_units             = '0;
        end else if (i_data_byte >= LEAD_6) begin
            n_acc     = {8'h00, i_data_byte & MASK_LEAD_6};
            n_pending = PEND_W'(5);
        end else if (i_data_byte >= LEAD_5) begin
            n_acc     = {8'h00, i_data_byte & MASK_LEAD_5};
            n_pending = PEND_W'(4);
        end else if (i_data_byte >= LEAD_4) begin
            n_acc     = {8'h00, i_data_byte & MASK_LEAD_4};
            n_pending = PEND_W'(3);
        end else if (i_data_byte >= LEAD_3) begin
            n_acc     = {8'h00, i_data_byte & MASK_LEAD_3};
            n_pending = PEND_W'(2);
        end else if (i_data_byte >= LEAD_2) begin
            n_acc     = {8'h00, i_data_byte & MASK_LEAD_2};
            n_pending = PEND_W'(1);
        end else begin
            unit_done = 1'b1;
        end

        if (unit_done) begin
            o_has_result = 1'b1;
            if (ovf) begin
                o_result.is_end     = 1'b1;
                o_result.overflow   = 1'b1;
                o_result.unit_count = {1'b0, i_capacity} + COUNT_W'(1);
                n_units             = '0;
                n_drop              = 1'b1;
            end else begin
                n_units             = r_units + COUNT_W'(1);
                o_result.code_unit  = unit_val;
                o_result.unit_count = r_units + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
            r_units   <= '0;
            r_drop    <= 1'b0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_units   <= n_units;
            r_drop    <= n_drop;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/u8d_out_reg.sv =====
`default_nettype none
module u8d_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire u8d_pkg::t_result  i_result,
    output logic                   o_free,
    u8d_result_if.source           o_result
);
    import u8d_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.code_unit  = r_result.code_unit;
    assign o_result.is_end     = r_result.is_end;
    assign o_result.overflow   = r_result.overflow;
    assign o_result.unit_count = r_result.unit_count;
endmodule
`default_nettype wire

// ===== rtl/core/u8d_checker.sv =====
`default_nettype none
module u8d_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_is_end,
    input  wire logic        i_overflow,
    input  wire logic [16:0] i_unit_count
);
    // overflow only on end results
    a_ovf_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_overflow) |-> i_is_end)
        else $error("overflow without end");

    // end results carry no code unit
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_is_end) |-> (i_code_unit == 16'h0000))
        else $error("end result with nonzero unit");

    // a code unit always counts itself
    a_unit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_is_end) |-> (i_unit_count != 17'h00000))
        else $error("code unit with zero count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_code_unit) && $stable(i_is_end)
            && $stable(i_overflow) && $stable(i_unit_count)))
        else $error("stalled result changed");
endmodule

bind utf8_to_ucs2_string_decoder u8d_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_code_unit  (o_result.code_unit),
    .i_is_end     (o_result.is_end),
    .i_overflow   (o_result.overflow),
    .i_unit_count (o_result.unit_count)
);
`default_nettype wire
